### rtl/core/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared types and constants for the echo escape decoder.
// ----------------------------------------------------------------------------
package ecd_pkg;

  localparam int unsigned ECD_FIFO_DEPTH = 4;
  localparam int unsigned ECD_MAX_RESULTS = 3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_VT    = 8'h0B;

  localparam logic [7:0] CH_LC_N = 8'h6E;
  localparam logic [7:0] CH_LC_T = 8'h74;
  localparam logic [7:0] CH_LC_R = 8'h72;
  localparam logic [7:0] CH_LC_A = 8'h61;
  localparam logic [7:0] CH_LC_B = 8'h62;
  localparam logic [7:0] CH_LC_F = 8'h66;
  localparam logic [7:0] CH_LC_V = 8'h76;

  localparam logic [1:0] OCTAL_MAX_DIGITS = 2'd3;

  localparam logic CFG_IDX_INTERPRET = 1'b0;
  localparam logic CFG_IDX_SUPPRESS  = 1'b1;

  typedef struct packed {
    logic esc_decode;
    logic suppress_newline;
  } ecd_cfg_t;

  // up to three decoded bytes produced by one input transaction
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } ecd_bundle_t;

  function automatic logic [7:0] escape_byte(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_LC_N: r = CH_NL;
      CH_LC_T: r = CH_TAB;
      CH_LC_R: r = CH_CR;
      CH_BSL:  r = CH_BSL;
      CH_LC_A: r = CH_BEL;
      CH_LC_B: r = CH_BS;
      CH_LC_F: r = CH_FF;
      CH_LC_V: r = CH_VT;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/ecd_front.sv
// ----------------------------------------------------------------------------
// ecd_front
// Accepts argument bytes, tracks escape state and builds a bundle of the
// bytes each transaction produces.
// ----------------------------------------------------------------------------
module ecd_front
  import ecd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ecd_cfg_t    cfg,
  input  logic        accept,
  input  logic [7:0]  ch,
  input  logic        has_char,
  input  logic        end_of_arg,
  input  logic        end_of_args,
  output logic        push,
  output ecd_bundle_t push_data
);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_OCTAL  = 2'd2
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [8:0] octal_value_r, octal_value_nxt;
  logic [1:0] octal_digits_r, octal_digits_nxt;

  logic [1:0]      cnt;
  logic [2:0][7:0] res;
  logic [8:0]      oct_acc;
  logic            is_octal;

  assign is_octal = (ch[7:3] == 5'b00110);
  assign oct_acc  = {octal_value_r[5:0], ch[2:0]};

  always_comb begin
    mode_nxt         = mode_r;
    octal_value_nxt  = octal_value_r;
    octal_digits_nxt = octal_digits_r;
    cnt              = 2'd0;
    res              = '0;

    if (has_char) begin
      case (mode_r)
        MODE_ESCAPE: begin
          if (ch == CH_ZERO) begin
            mode_nxt         = MODE_OCTAL;
            octal_value_nxt  = '0;
            octal_digits_nxt = '0;
          end else begin
            mode_nxt = MODE_NORMAL;
            res[cnt] = escape_byte(ch);
            cnt      = cnt + 2'd1;
          end
        end
        MODE_OCTAL: begin
          if (is_octal && (octal_digits_r < OCTAL_MAX_DIGITS)) begin
            if ((octal_digits_r + 2'd1) == OCTAL_MAX_DIGITS) begin
              res[cnt]         = oct_acc[7:0];
              cnt              = cnt + 2'd1;
              mode_nxt         = MODE_NORMAL;
              octal_value_nxt  = '0;
              octal_digits_nxt = '0;
            end else begin
              octal_value_nxt  = oct_acc;
              octal_digits_nxt = octal_digits_r + 2'd1;
            end
          end else begin
            // collected byte first, then this byte in normal mode
            res[cnt]         = octal_value_r[7:0];
            cnt              = cnt + 2'd1;
            mode_nxt         = MODE_NORMAL;
            octal_value_nxt  = '0;
            octal_digits_nxt = '0;
            if (cfg.esc_decode && (ch == CH_BSL)) begin
              mode_nxt = MODE_ESCAPE;
            end else begin
              res[cnt] = ch;
              cnt      = cnt + 2'd1;
            end
          end
        end
        default: begin
          mode_nxt = MODE_NORMAL;
          if (cfg.esc_decode && (ch == CH_BSL)) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            res[cnt] = ch;
            cnt      = cnt + 2'd1;
          end
        end
      endcase
    end

    if (end_of_arg || end_of_args) begin
      if (mode_nxt == MODE_ESCAPE) begin
        res[cnt] = CH_BSL;
        cnt      = cnt + 2'd1;
      end else if (mode_nxt == MODE_OCTAL) begin
        res[cnt] = octal_value_nxt[7:0];
        cnt      = cnt + 2'd1;
      end
      mode_nxt         = MODE_NORMAL;
      octal_value_nxt  = '0;
      octal_digits_nxt = '0;
      if (end_of_args) begin
        if (!cfg.suppress_newline) begin
          res[cnt] = CH_NL;
          cnt      = cnt + 2'd1;
        end
      end else begin
        res[cnt] = CH_SPACE;
        cnt      = cnt + 2'd1;
      end
    end
  end

  assign push            = accept && (cnt != 2'd0);
  assign push_data.cnt   = cnt;
  assign push_data.bytes = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_NORMAL;
      octal_value_r  <= '0;
      octal_digits_r <= '0;
    end else if (accept) begin
      mode_r         <= mode_nxt;
      octal_value_r  <= octal_value_nxt;
      octal_digits_r <= octal_digits_nxt;
    end
  end

endmodule

### rtl/core/ecd_fifo.sv
// ----------------------------------------------------------------------------
// ecd_fifo
// Small queue of decoded bundles between the front and back parts.
// ----------------------------------------------------------------------------
module ecd_fifo
  import ecd_pkg::*;
#(
  parameter int unsigned DEPTH = ECD_FIFO_DEPTH
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  ecd_bundle_t push_data,
  output logic        full,
  input  logic        pop,
  output ecd_bundle_t pop_data,
  output logic        empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ecd_bundle_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop && !empty) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/core/ecd_back.sv
// ----------------------------------------------------------------------------
// ecd_back
// Pulls queued bundles and sends their bytes one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ecd_back
  import ecd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        empty,
  input  ecd_bundle_t pop_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  ecd_bundle_t cur_r;
  logic [1:0]  idx_r;
  logic        busy_r;
  logic        fire;
  logic        at_last;

  assign at_last   = (idx_r == (cur_r.cnt - 2'd1));
  assign fire      = busy_r && !out_stall;
  // take the next bundle when idle or when the last byte leaves
  assign pop       = !empty && (!busy_r || (fire && at_last));

  assign out_valid = busy_r;
  assign out_byte  = cur_r.bytes[idx_r];
  assign out_last  = at_last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (fire) begin
      if (at_last) begin
        busy_r <= 1'b0;
        idx_r  <= '0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

### rtl/core/echo_escape_decoder_top.sv
// ----------------------------------------------------------------------------
// echo_escape_decoder_top
// Streaming decoder for echo arguments with backslash escape handling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one argument byte per transaction with flags for
//   end of argument and end of list. A transaction happens when in_valid is
//   high and in_stall is low. Each input transaction yields zero to three
//   output bytes; the last one carries out_last.
//   Output channel (out_*): one decoded byte per transaction.
//   Config port (cfg_*): write cfg_wdata to register cfg_index when cfg_we is
//   high; 0 = escape decoding on (reset 1), 1 = suppress_newline (reset 0).
//   Write only while the decoder is idle.
// Timing:
//   out_valid rises once the bundle has passed through the queue and
//   been loaded into the output register of ecd_back.
//   One input transaction per cycle is accepted while the queue is not
//   full; the output side sends one byte per cycle while out_stall is low,
//   so throughput is set by the output port and by the bytes each item
//   produces (one in the common case, up to three). The bundle queue
//   absorbs short bursts. When out_stall is high the byte holds; once the
//   queue fills, in_stall rises. Reset (synchronous, rst_n low) empties the
//   queue, clears the escape state and restores register defaults.
// ----------------------------------------------------------------------------
module echo_escape_decoder_top
  import ecd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = ECD_FIFO_DEPTH
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_has_char,
  input  logic       in_end_of_arg,
  input  logic       in_end_of_args,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  ecd_cfg_t    cfg_r;
  logic        full;
  logic        empty;
  logic        push;
  logic        pop;
  logic        in_accept;
  ecd_bundle_t push_data;
  ecd_bundle_t pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.esc_decode       <= 1'b1;
      cfg_r.suppress_newline <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_INTERPRET: cfg_r.esc_decode       <= cfg_wdata;
        CFG_IDX_SUPPRESS:  cfg_r.suppress_newline <= cfg_wdata;
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_stall  = full;
  assign in_accept = in_valid && !in_stall;

  ecd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (in_accept),
    .ch          (in_ch),
    .has_char    (in_has_char),
    .end_of_arg  (in_end_of_arg),
    .end_of_args (in_end_of_args),
    .push        (push),
    .push_data   (push_data)
  );

  ecd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  ecd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

### rtl/core/ecd_checker.sv
// ----------------------------------------------------------------------------
// ecd_checker
// Port-level assertions for the echo escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ecd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // reset leaves nothing to send and the input open
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output valid or input stalled after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output transaction changed");

  // bytes of one input transaction leave without gaps
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("burst broken before last byte");

  // no output appears without a recent input transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && !in_stall) && !$past(in_valid && !in_stall)
      |=> !out_valid)
    else $error("output appeared without input");

endmodule

bind echo_escape_decoder_top ecd_checker u_ecd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_last  (out_last)
);

### test/echo_escape_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_escape_decoder_checker
// Watches the config port and both streams of the echo escape decoder, keeps
// its own copy of the escape state and registers, queues the decoded bytes
// each input transaction should produce and compares every output
// transaction against the oldest queued byte.
// ----------------------------------------------------------------------------
module echo_escape_decoder_checker
  import ecd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_has_char,
  input  logic        in_end_of_arg,
  input  logic        in_end_of_args,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef enum logic [1:0] {
    DEC_NORMAL = 2'd0,
    DEC_ESCAPE = 2'd1,
    DEC_OCTAL  = 2'd2
  } dec_mode_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } decoded_byte_t;

  ecd_cfg_t        mirror_cfg;
  dec_mode_t       mode;
  logic [8:0]      octal_acc;
  logic [1:0]      octal_cnt;
  decoded_byte_t   expected_bytes[$];
  int unsigned     errors_seen = 0;

  function automatic logic [7:0] control_code(input logic [7:0] c);
    case (c)
      CH_LC_N: return CH_NL;
      CH_LC_T: return CH_TAB;
      CH_LC_R: return CH_CR;
      CH_LC_A: return CH_BEL;
      CH_LC_B: return CH_BS;
      CH_LC_F: return CH_FF;
      CH_LC_V: return CH_VT;
      default: return c;   // backslash and unknown letters map to themselves
    endcase
  endfunction

  // Bytes one input transaction decodes to, appended to expected_bytes.
  function automatic void decode_item(input logic [7:0] c, input logic has,
                                      input logic eoa, input logic eol);
    logic [7:0]    outb[3];
    int            n;
    logic          octal_digit;
    decoded_byte_t d;
    n = 0;
    if (has) begin
      octal_digit = (c >= CH_ZERO) && (c <= CH_ZERO + 8'd7) &&
                    (octal_cnt < OCTAL_MAX_DIGITS);
      // a non-digit closes the octal run, then is decoded as a fresh byte
      if (mode == DEC_OCTAL && !octal_digit) begin
        outb[n] = octal_acc[7:0];
        n++;
        mode = DEC_NORMAL;
        octal_acc = '0;
        octal_cnt = '0;
      end
      if (mode == DEC_ESCAPE) begin
        if (c == CH_ZERO) begin
          mode = DEC_OCTAL;
          octal_acc = '0;
          octal_cnt = '0;
        end else begin
          mode = DEC_NORMAL;
          outb[n] = control_code(c);
          n++;
        end
      end else if (mode == DEC_OCTAL) begin
        octal_acc = {octal_acc[5:0], 3'b000} + 9'(c - CH_ZERO);
        octal_cnt++;
        if (octal_cnt == OCTAL_MAX_DIGITS) begin
          outb[n] = octal_acc[7:0];
          n++;
          mode = DEC_NORMAL;
          octal_acc = '0;
          octal_cnt = '0;
        end
      end else if (mirror_cfg.esc_decode && c == CH_BSL) begin
        mode = DEC_ESCAPE;
      end else begin
        outb[n] = c;
        n++;
      end
    end
    if (eoa || eol) begin
      if (mode == DEC_ESCAPE) begin
        outb[n] = CH_BSL;
        n++;
      end else if (mode == DEC_OCTAL) begin
        outb[n] = octal_acc[7:0];
        n++;
      end
      mode = DEC_NORMAL;
      octal_acc = '0;
      octal_cnt = '0;
      if (!eol) begin
        outb[n] = CH_SPACE;
        n++;
      end else if (!mirror_cfg.suppress_newline) begin
        outb[n] = CH_NL;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      d.value = outb[i];
      d.last  = (i == n - 1);
      expected_bytes.push_back(d);
    end
  endfunction

  always @(posedge clk) begin
    decoded_byte_t head;
    if (!rst_n) begin
      mirror_cfg.esc_decode       = 1'b1;
      mirror_cfg.suppress_newline = 1'b0;
      mode = DEC_NORMAL;
      octal_acc = '0;
      octal_cnt = '0;
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          errors_seen++;
          $error("out_byte: no transaction expected, actual %h", out_byte);
        end else begin
          head = expected_bytes.pop_front();
          if (out_byte !== head.value) begin
            errors_seen++;
            $error("out_byte: expected %h, actual %h", head.value, out_byte);
          end
          if (out_last !== head.last) begin
            errors_seen++;
            $error("out_last: expected %b, actual %b", head.last, out_last);
          end
        end
      end
      if (in_valid && !in_stall)
        decode_item(in_ch, in_has_char, in_end_of_arg, in_end_of_args);
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_INTERPRET: mirror_cfg.esc_decode       = cfg_wdata;
          CFG_IDX_SUPPRESS:  mirror_cfg.suppress_newline = cfg_wdata;
          default: ;
        endcase
      end
    end
    fail_count <= errors_seen;
    pending    <= expected_bytes.size();
  end

endmodule

### test/echo_escape_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_escape_decoder_top_tb
// Drives argument bytes into the echo escape decoder: a directed pass over
// the escape letters, octal runs, argument ends and register changes in the
// middle of an escape, then random argument lists under several register
// settings with random stalls on both sides. Checking is done by the
// checker instance; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module echo_escape_decoder_top_tb
  import ecd_pkg::*;
();

  localparam int unsigned RANDOM_ITEMS   = 150;
  localparam int unsigned PHASE_ITEMS    = 35;
  localparam int unsigned QUIET_ITEMS    = 40;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic       cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_ch;
  logic       in_has_char;
  logic       in_end_of_arg;
  logic       in_end_of_args;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          hold_req = 1'b0;

  // escape decoding, suppress_newline for the first random phases
  bit [1:0] phase_cfg [4] = '{2'b11, 2'b00, 2'b10, 2'b01};

  echo_escape_decoder_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .in_has_char    (in_has_char),
    .in_end_of_arg  (in_end_of_arg),
    .in_end_of_args (in_end_of_args),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last)
  );

  echo_escape_decoder_checker decode_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .in_has_char    (in_has_char),
    .in_end_of_arg  (in_end_of_arg),
    .in_end_of_args (in_end_of_args),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("echo_escape_decoder_top_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output-side back-pressure: random bursts, or one long hold on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Called at a clock edge; returns at the edge where the transaction is taken.
  // in_valid is left high so a following item goes out back to back.
  task automatic send_item(input logic [7:0] c, input logic has,
                           input logic eoa, input logic eol);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_ch          <= c;
    in_has_char    <= has;
    in_end_of_arg  <= eoa;
    in_end_of_args <= eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (has || eoa || eol) items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(c, 1'b1, 1'b0, 1'b0);
  endtask

  // Lets every expected byte drain, plus a margin for items still in flight
  // that produce nothing.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic interp, input logic suppress);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_INTERPRET;
    cfg_wdata <= interp;
    @(posedge clk);
    cfg_index <= CFG_IDX_SUPPRESS;
    cfg_wdata <= suppress;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] escape_letter();
    case ($urandom_range(0, 8))
      0: return CH_LC_N;
      1: return CH_LC_T;
      2: return CH_LC_R;
      3: return CH_BSL;
      4: return CH_LC_A;
      5: return CH_LC_B;
      6: return CH_LC_F;
      7: return CH_LC_V;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_arg(input bit final_arg);
    logic [7:0]  text[$];
    int unsigned kind;
    bit          flag_on_byte;
    logic        eoa;
    repeat ($urandom_range(0, 4)) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        text.push_back(8'($urandom));
      end else if (kind < 6) begin
        text.push_back(CH_BSL);
        text.push_back(escape_letter());
      end else if (kind < 9) begin
        text.push_back(CH_BSL);
        text.push_back(CH_ZERO);
        // up to four digits, with 8 and 9 thrown in to break the run
        repeat ($urandom_range(0, 4)) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end else begin
        text.push_back(CH_BSL);
      end
    end
    flag_on_byte = (text.size() != 0) && ($urandom_range(0, 1) == 1);
    eoa = final_arg ? 1'($urandom_range(0, 1)) : 1'b1;
    for (int i = 0; i < text.size(); i++) begin
      if (flag_on_byte && i == text.size() - 1)
        send_item(text[i], 1'b1, eoa, final_arg);
      else
        send_char(text[i]);
    end
    if (!flag_on_byte) send_item(8'($urandom), 1'b0, eoa, final_arg);
  endtask

  task automatic send_random_list();
    int unsigned n_args;
    if ($urandom_range(0, 5) == 0) begin
      // noise: unstructured transactions with random flags
      repeat ($urandom_range(1, 6))
        send_item(8'($urandom), 1'($urandom), $urandom_range(0, 3) == 0,
                  $urandom_range(0, 5) == 0);
    end else begin
      n_args = $urandom_range(1, 4);
      for (int a = 0; a < n_args; a++) send_random_arg(a == n_args - 1);
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned phase_end;
    bit          quiet;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_IDX_INTERPRET;
    cfg_wdata      = 1'b0;
    in_valid       = 1'b0;
    in_ch          = 8'h00;
    in_has_char    = 1'b0;
    in_end_of_arg  = 1'b0;
    in_end_of_args = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults: escapes decoded, newline kept
    send_char(8'h00);
    send_item(8'hFF, 1'b1, 1'b1, 1'b0);
    send_char(CH_BSL); send_char(CH_LC_N);
    send_char(CH_BSL); send_char(CH_LC_V);
    send_char(CH_BSL); send_char(CH_BSL);
    // three octal digits complete the byte; 0777 truncates to 8 bits
    send_char(CH_BSL); send_char(CH_ZERO);
    send_char(CH_ZERO + 8'd7); send_char(CH_ZERO + 8'd7); send_char(CH_ZERO + 8'd7);
    // octal run cut short by a backslash that starts a new escape
    send_char(CH_BSL); send_char(CH_ZERO); send_char(CH_ZERO + 8'd5);
    send_char(CH_BSL); send_char(CH_LC_B);
    // trailing backslash and trailing octal at argument end
    send_item(CH_BSL, 1'b1, 1'b1, 1'b0);
    send_char(CH_BSL); send_char(CH_ZERO);
    send_item(CH_ZERO + 8'd4, 1'b1, 1'b1, 1'b0);
    // empty arguments still get their separator
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0, 1'b1);
    send_item(8'h78, 1'b1, 1'b1, 1'b1);

    // escape opened, then decoding switched off: the escape still completes
    send_char(CH_BSL);
    wait_idle();
    write_cfg(1'b0, 1'b1);
    send_char(CH_ZERO);
    send_char(CH_ZERO + 8'd3);
    send_char(CH_BSL);
    send_item(CH_BSL, 1'b1, 1'b0, 1'b1);

    target = items_sent + RANDOM_ITEMS;
    for (int p = 0; items_sent < target; p++) begin
      wait_idle();
      if (p < 4)
        write_cfg(phase_cfg[p][1], phase_cfg[p][0]);
      else
        write_cfg(1'($urandom), 1'($urandom));
      quiet      = (items_sent + QUIET_ITEMS >= target);
      tx_idle_on = !quiet && (p != 2);
      rx_idle_on = !quiet;
      // long output hold while items keep coming, so the input stalls
      if (p == 2) hold_req = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < target) send_random_list();
    end

    wait_idle();
    if (fail_count == 0 && pending == 0)
      $display("echo_escape_decoder_top_tb: done, clean");
    else
      $display("echo_escape_decoder_top_tb: done, errors");
    $finish;
  end

endmodule
